// ===== rtl/rhla_pkg.sv =====
// ============================================================================
// rhla_pkg
// Shared constants and types for the RGB/HSL lightness adjuster.
// ============================================================================
package rhla_pkg;

    // Fixed point format used on the HSL to RGB side.
    localparam int FRAC_BITS = 16;
    localparam int FXW       = FRAC_BITS + 2;
    localparam int PW2       = 2 * FXW;

    localparam logic [FXW-1:0] FX_ONE      = FXW'(1) << FRAC_BITS;
    localparam logic [FXW-1:0] FX_HALF     = FXW'(1) << (FRAC_BITS - 1);
    localparam logic [FXW-1:0] FX_THIRD    = FXW'(((longint'(1) << FRAC_BITS) + 1) / 3);
    localparam logic [FXW-1:0] FX_SIXTH    = FXW'(((longint'(1) << FRAC_BITS) + 3) / 6);
    localparam logic [FXW-1:0] FX_TWOTHIRD = FXW'(((longint'(2) << FRAC_BITS) + 1) / 3);

    // Lightness in thousandths: floor(N / 1020) by reciprocal, N < 2^20.
    localparam int             LIG_NW = 20;
    localparam int             LIG_PW = 42;
    localparam int             LIG_SH = 31;
    localparam logic [21:0]    LIG_K  = 22'd2105377;

    // Thousandths to fixed point: round(v * ONE / 1000) by reciprocal.
    localparam int     MIL_SH  = FRAC_BITS + 15;
    localparam longint MIL_K   = ((longint'(1) << MIL_SH) + 124) / 125;
    localparam longint MIL_C   = (62 * MIL_K) >> (FRAC_BITS - 3);
    localparam int     MIL_PW  = FRAC_BITS + 20;
    localparam int     MIL_RSH = 18;

    // Degrees to fixed point: round(v * ONE / 360) by reciprocal.
    localparam int     HUE_SH  = FRAC_BITS + 13;
    localparam longint HUE_K   = ((longint'(1) << HUE_SH) + 44) / 45;
    localparam longint HUE_C   = (22 * HUE_K) >> (FRAC_BITS - 3);
    localparam int     HUE_PW  = FRAC_BITS + 18;
    localparam int     HUE_RSH = 16;

    // Pipelined divider sizes: numerator, divisor and quotient widths.
    localparam int DIV_NW = 19;
    localparam int DIV_DW = 9;
    localparam int DIV_QW = 10;

    // Reset value of the lightness offset register.
    localparam logic signed [7:0] DELTA_RST = 8'sd10;

    // Piece of the hue-to-channel curve that a channel hue falls in.
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } t_seg;

endpackage

// ===== rtl/rhla_in_if.sv =====
// ============================================================================
// rhla_in_if
// Input pixel channel: valid/ready handshake with one RGB pixel per beat.
// ============================================================================
interface rhla_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/rhla_out_if.sv =====
// ============================================================================
// rhla_out_if
// Output pixel channel: valid/ready handshake with one RGB pixel per beat.
// ============================================================================
interface rhla_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    output ready);
endinterface

// ===== rtl/rhla_div.sv =====
// ============================================================================
// rhla_div
// Restoring divider, one quotient bit per pipeline stage, quotient < 2^DIV_QW.
// ============================================================================
module rhla_div import rhla_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic [DIV_QW-1:0] o_quo
);

    // The last stage only produces the quotient, so remainder and divisor
    // are carried through the first DIV_QW-1 stages only.
    logic [DIV_NW-1:0] r_rem [DIV_QW-1];
    logic [DIV_DW-1:0] r_den [DIV_QW-1];
    logic [DIV_QW-1:0] r_quo [DIV_QW];

    genvar k;
    generate
        for (k = 0; k < DIV_QW; k++) begin : g_step
            logic [DIV_NW-1:0] w_rem_in;
            logic [DIV_DW-1:0] w_den_in;
            logic [DIV_QW-1:0] w_quo_in;
            logic [DIV_NW-1:0] w_sub;
            logic              w_fit;

            // The first stage takes the operands, later ones the previous stage.
            if (k == 0) begin : g_first
                assign w_rem_in = i_num;
                assign w_den_in = i_den;
                assign w_quo_in = '0;
            end else begin : g_next
                assign w_rem_in = r_rem[k-1];
                assign w_den_in = r_den[k-1];
                assign w_quo_in = r_quo[k-1];
            end

            // Try to take the shifted divisor out of the partial remainder.
            assign w_sub = DIV_NW'(w_den_in) << (DIV_QW - 1 - k);
            assign w_fit = (w_rem_in >= w_sub);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_quo[k] <= w_fit ? (w_quo_in | (DIV_QW'(1) << (DIV_QW - 1 - k)))
                                      : w_quo_in;
                end
            end

            // Remainder and divisor for the next stage.
            if (k < DIV_QW - 1) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[k] <= w_fit ? (w_rem_in - w_sub) : w_rem_in;
                        r_den[k] <= w_den_in;
                    end
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[DIV_QW-1];

endmodule

// ===== rtl/rgb_hsl_lightness_adjust.sv =====
// An accepted input beat moves through every pipeline stage to the output register.
// Throughput: one pixel per cycle while the output is not stalled; the two 10-stage
// pipelined dividers (saturation and hue) set the depth, and the whole pipeline
// advances together on one enable. A stalled output freezes every stage; bubbles
// are not squeezed out. Reset (synchronous, active low) clears all valid bits and
// loads the lightness offset register with 10; data registers are not reset.
// ============================================================================
// rgb_hsl_lightness_adjust
// Converts RGB to HSL, offsets lightness by a signed percent, converts back.
// ============================================================================
module rgb_hsl_lightness_adjust import rhla_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    rhla_in_if.sink     i_pix,
    rhla_out_if.source  o_pix
);

    localparam int NSTG = 19;

    logic              w_en;
    logic              w_acc;
    logic [NSTG:1]     r_vld;
    logic signed [7:0] r_delta;

    // Every stage moves when the output stage is empty or being taken.
    assign w_en        = !r_vld[NSTG] || o_pix.ready;
    assign w_acc       = i_pix.valid && w_en;
    assign i_pix.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-1:1], w_acc};
        end
    end

    // Lightness offset register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta <= DELTA_RST;
        end else if (i_cfg_wr_en) begin
            r_delta <= signed'(i_cfg_wr_data);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: extremes, sums and the two division operands.
    // ------------------------------------------------------------------
    logic [7:0]         w_mx, w_mn, w_d;
    logic [8:0]         w_sum, w_sden;
    logic signed [19:0] w_hnum, w_hn2;

    always_comb begin
        w_mx = i_pix.red;
        if (i_pix.green > w_mx) w_mx = i_pix.green;
        if (i_pix.blue > w_mx)  w_mx = i_pix.blue;
        w_mn = i_pix.red;
        if (i_pix.green < w_mn) w_mn = i_pix.green;
        if (i_pix.blue < w_mn)  w_mn = i_pix.blue;
        w_sum  = 9'(w_mx) + 9'(w_mn);
        w_d    = w_mx - w_mn;
        w_sden = (w_sum > 9'd255) ? (9'd510 - w_sum) : w_sum;
        if (w_mx == i_pix.red) begin
            w_hnum = 20'sd60 * (signed'(20'(i_pix.green)) - signed'(20'(i_pix.blue)))
                   + ((i_pix.green < i_pix.blue) ? 20'sd360 * signed'(20'(w_d)) : 20'sd0);
        end else if (w_mx == i_pix.green) begin
            w_hnum = 20'sd60 * (signed'(20'(i_pix.blue)) - signed'(20'(i_pix.red)))
                   + 20'sd120 * signed'(20'(w_d));
        end else begin
            w_hnum = 20'sd60 * (signed'(20'(i_pix.red)) - signed'(20'(i_pix.green)))
                   + 20'sd240 * signed'(20'(w_d));
        end
        w_hn2 = (w_hnum <<< 1) + signed'(20'(w_d));
    end

    logic [LIG_NW-1:0] r_s1_lnum;
    logic [DIV_NW-1:0] r_s1_snum, r_s1_hnum;
    logic [DIV_DW-1:0] r_s1_sdiv, r_s1_hdiv;
    logic              r_s1_nz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_lnum <= LIG_NW'(w_sum) * LIG_NW'(2000) + LIG_NW'(510);
            r_s1_snum <= DIV_NW'(w_d) * DIV_NW'(2000) + DIV_NW'(w_sden);
            r_s1_sdiv <= DIV_DW'(w_sden) << 1;
            r_s1_hnum <= DIV_NW'(w_hn2);
            r_s1_hdiv <= DIV_DW'(w_d) << 1;
            r_s1_nz   <= (w_d != 8'd0);
        end
    end

    // ------------------------------------------------------------------
    // Stages 2..11: saturation and hue dividers; lightness by reciprocal.
    // ------------------------------------------------------------------
    logic [DIV_QW-1:0] w_sat, w_hue;

    rhla_div u_sat_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_s1_snum),
        .i_den (r_s1_sdiv),
        .o_quo (w_sat)
    );

    rhla_div u_hue_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_s1_hnum),
        .i_den (r_s1_hdiv),
        .o_quo (w_hue)
    );

    logic [9:0] r_s2_lig;
    logic [9:0] r_lig_d [DIV_QW-1];
    logic       r_nz_d  [DIV_QW];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_lig   <= 10'((LIG_PW'(r_s1_lnum) * LIG_PW'(LIG_K)) >> LIG_SH);
            r_lig_d[0] <= r_s2_lig;
            for (int k = 1; k < DIV_QW - 1; k++) begin
                r_lig_d[k] <= r_lig_d[k-1];
            end
            r_nz_d[0] <= r_s1_nz;
            for (int k = 1; k < DIV_QW; k++) begin
                r_nz_d[k] <= r_nz_d[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 12: hue wrap, grey override, lightness offset and clamp.
    // ------------------------------------------------------------------
    logic signed [12:0] w_ladj;
    logic [9:0]         r_s12_lig, r_s12_sat;
    logic [8:0]         r_s12_hue;

    assign w_ladj = signed'(13'(r_lig_d[DIV_QW-2])) + 13'sd10 * 13'(r_delta);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s12_hue <= (!r_nz_d[DIV_QW-1] || w_hue >= 10'd360) ? 9'd0 : w_hue[8:0];
            r_s12_sat <= r_nz_d[DIV_QW-1] ? w_sat : 10'd0;
            if (w_ladj < 13'sd0) begin
                r_s12_lig <= 10'd0;
            end else if (w_ladj > 13'sd1000) begin
                r_s12_lig <= 10'd1000;
            end else begin
                r_s12_lig <= w_ladj[9:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 13..14: scale L, S and H to fixed point.
    // ------------------------------------------------------------------
    logic [MIL_PW-1:0] r_s13_lp, r_s13_sp;
    logic [HUE_PW-1:0] r_s13_hp;
    logic              r_s13_lo;
    logic [FXW-1:0]    r_s14_l, r_s14_s, r_s14_h;
    logic              r_s14_lo;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s13_lp <= MIL_PW'(r_s12_lig) * MIL_PW'(MIL_K);
            r_s13_sp <= MIL_PW'(r_s12_sat) * MIL_PW'(MIL_K);
            r_s13_hp <= HUE_PW'(r_s12_hue) * HUE_PW'(HUE_K);
            r_s13_lo <= (r_s12_lig < 10'd500);
            r_s14_l  <= FXW'((r_s13_lp + MIL_PW'(MIL_C)) >> MIL_RSH);
            r_s14_s  <= FXW'((r_s13_sp + MIL_PW'(MIL_C)) >> MIL_RSH);
            r_s14_h  <= FXW'((r_s13_hp + HUE_PW'(HUE_C)) >> HUE_RSH);
            r_s14_lo <= r_s13_lo;
        end
    end

    // ------------------------------------------------------------------
    // Stage 15: l*s product and the three channel hues.
    // ------------------------------------------------------------------
    logic [PW2-1:0] r_s15_ls;
    logic [FXW-1:0] r_s15_l, r_s15_s;
    logic [FXW-1:0] r_s15_t [3];
    logic           r_s15_lo;
    logic [FXW-1:0] w_t0;

    assign w_t0 = r_s14_h + FX_THIRD;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s15_ls   <= PW2'(r_s14_l) * PW2'(r_s14_s);
            r_s15_l    <= r_s14_l;
            r_s15_s    <= r_s14_s;
            r_s15_lo   <= r_s14_lo;
            r_s15_t[0] <= (w_t0 > FX_ONE) ? (w_t0 - FX_ONE) : w_t0;
            r_s15_t[1] <= r_s14_h;
            r_s15_t[2] <= (r_s14_h >= FX_THIRD) ? (r_s14_h - FX_THIRD)
                                                : (r_s14_h + FX_ONE - FX_THIRD);
        end
    end

    // ------------------------------------------------------------------
    // Stage 16: q and p, and each channel's curve piece and slope operand.
    // ------------------------------------------------------------------
    logic [FXW-1:0] w_m, w_q, w_p;
    t_seg           w_seg [3];
    logic [FXW-1:0] w_op  [3];

    always_comb begin
        w_m = FXW'((r_s15_ls + PW2'(FX_HALF)) >> FRAC_BITS);
        w_q = r_s15_lo ? (r_s15_l + w_m) : (r_s15_l + r_s15_s - w_m);
        w_p = (r_s15_l << 1) - w_q;
        for (int k = 0; k < 3; k++) begin
            if (r_s15_t[k] < FX_SIXTH) begin
                w_seg[k] = SEG_RISE;
                w_op[k]  = r_s15_t[k] * FXW'(6);
            end else if (r_s15_t[k] < FX_HALF) begin
                w_seg[k] = SEG_HIGH;
                w_op[k]  = '0;
            end else if (r_s15_t[k] < FX_TWOTHIRD) begin
                w_seg[k] = SEG_FALL;
                w_op[k]  = (FX_TWOTHIRD - r_s15_t[k]) * FXW'(6);
            end else begin
                w_seg[k] = SEG_LOW;
                w_op[k]  = '0;
            end
        end
    end

    logic [FXW-1:0] r_s16_p, r_s16_q, r_s16_dq;
    t_seg           r_s16_seg [3];
    logic [FXW-1:0] r_s16_op  [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s16_p  <= w_p;
            r_s16_q  <= w_q;
            r_s16_dq <= w_q - w_p;
            for (int k = 0; k < 3; k++) begin
                r_s16_seg[k] <= w_seg[k];
                r_s16_op[k]  <= w_op[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 17: slope products for the three channels.
    // ------------------------------------------------------------------
    logic [PW2-1:0] r_s17_prod [3];
    t_seg           r_s17_seg  [3];
    logic [FXW-1:0] r_s17_p, r_s17_q;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s17_p <= r_s16_p;
            r_s17_q <= r_s16_q;
            for (int k = 0; k < 3; k++) begin
                r_s17_prod[k] <= PW2'(r_s16_dq) * PW2'(r_s16_op[k]);
                r_s17_seg[k]  <= r_s16_seg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 18: channel value in fixed point.
    // ------------------------------------------------------------------
    logic [FXW-1:0] r_s18_x [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                case (r_s17_seg[k])
                    SEG_RISE, SEG_FALL: begin
                        r_s18_x[k] <= r_s17_p
                                    + FXW'((r_s17_prod[k] + PW2'(FX_HALF)) >> FRAC_BITS);
                    end
                    SEG_HIGH: begin
                        r_s18_x[k] <= r_s17_q;
                    end
                    default: begin
                        r_s18_x[k] <= r_s17_p;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 19: scale to 0..255 with rounding and clamp; output register.
    // ------------------------------------------------------------------
    logic [FXW+7:0] w_y [3];
    logic [9:0]     w_c [3];
    logic [7:0]     r_out [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_y[k] = (FXW+8)'(r_s18_x[k]) * (FXW+8)'(255) + (FXW+8)'(FX_HALF);
            w_c[k] = 10'(w_y[k] >> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_out[k] <= (w_c[k] > 10'd255) ? 8'd255 : w_c[k][7:0];
            end
        end
    end

    assign o_pix.valid     = r_vld[NSTG];
    assign o_pix.out_red   = r_out[0];
    assign o_pix.out_green = r_out[1];
    assign o_pix.out_blue  = r_out[2];

endmodule

// ===== rtl/rhla_chk.sv =====
// ============================================================================
// rhla_chk
// Port-level checks on the lightness adjuster, attached by bind.
// ============================================================================
module rhla_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_red,
    input logic [7:0] i_out_green,
    input logic [7:0] i_out_blue
);

    // A stalled output beat holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_red)
            && $stable(i_out_green) && $stable(i_out_blue)))
        else $error("stalled output beat changed");

    // The pipeline stalls as a whole: a blocked output blocks the input.
    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input accepted while output stalled");

    // Whenever the sink is ready, the block is ready for a new beat too.
    a_flow: assert property (@(posedge i_clk)
        i_out_ready |-> i_in_ready)
        else $error("input blocked while output flows");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind rgb_hsl_lightness_adjust rhla_chk u_rhla_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_red   (o_pix.out_red),
    .i_out_green (o_pix.out_green),
    .i_out_blue  (o_pix.out_blue)
);

// ===== tb/tb_pixel_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_pixel_checker
// Watches both pixel channels and the offset register port, works out the
// adjusted pixel for every accepted input beat, and compares output beats.
// ============================================================================
module tb_pixel_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    rhla_in_if.sink    i_pix,
    rhla_out_if.sink   o_pix,
    output int         o_errors,
    output int         o_pixels_out
);
    localparam int FB = 16;
    localparam longint ONE = longint'(1) << FB;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    t_rgb    expected_pixels[$];
    int      lightness_offset;

    // Division rounded to nearest, ties away from zero.
    function automatic longint div_round(longint num, longint den);
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic longint curve_level(longint p, longint q, longint t);
        longint sixth, twothird;
        sixth    = div_round(ONE, 6);
        twothird = div_round(2 * ONE, 3);
        if (t < 0) t += ONE;
        if (t > ONE) t -= ONE;
        if (t < sixth) return p + div_round((q - p) * 6 * t, ONE);
        if (t < ONE / 2) return q;
        if (t < twothird) return p + div_round((q - p) * (twothird - t) * 6, ONE);
        return p;
    endfunction

    function automatic logic [7:0] level_to_byte(longint x);
        longint c;
        c = div_round(x * 255, ONE);
        if (c < 0) c = 0;
        if (c > 255) c = 255;
        return 8'(c);
    endfunction

    // Full RGB -> HSL -> offset -> RGB conversion of one pixel.
    function automatic t_rgb adjust_pixel(t_rgb px, int offset);
        int     r, g, b, mx, mn, sum, d, hue, sat, lig, den, num;
        longint l, s, h, q, p, m, third;
        t_rgb   res;
        r = int'(px.red); g = int'(px.green); b = int'(px.blue);
        mx = r; mn = r; hue = 0; sat = 0;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        sum = mx + mn;
        d   = mx - mn;
        lig = (2 * sum * 1000 + 510) / 1020;
        if (d != 0) begin
            den = (sum > 255) ? 510 - sum : sum;
            sat = (2 * d * 1000 + den) / (2 * den);
            if (mx == r) num = 60 * (g - b) + ((g < b) ? 360 * d : 0);
            else if (mx == g) num = 60 * (b - r) + 120 * d;
            else num = 60 * (r - g) + 240 * d;
            hue = (2 * num + d) / (2 * d);
            if (hue >= 360) hue = 0;
        end
        lig += 10 * offset;
        if (lig < 0) lig = 0;
        if (lig > 1000) lig = 1000;
        l = div_round(longint'(lig) * ONE, 1000);
        s = div_round(longint'(sat) * ONE, 1000);
        h = div_round(longint'(hue) * ONE, 360);
        if (sat == 0) begin
            res.red = level_to_byte(l);
            res.green = res.red;
            res.blue = res.red;
            return res;
        end
        m = div_round(l * s, ONE);
        q = (lig < 500) ? l + m : l + s - m;
        p = 2 * l - q;
        third = div_round(ONE, 3);
        res.red   = level_to_byte(curve_level(p, q, h + third));
        res.green = level_to_byte(curve_level(p, q, h));
        res.blue  = level_to_byte(curve_level(p, q, h - third));
        return res;
    endfunction

    // Track the register, queue predictions, and compare output beats.
    always @(posedge i_clk) begin
        t_rgb want;
        t_rgb got;
        if (!i_rst_n) begin
            lightness_offset = 10;
            expected_pixels.delete();
            o_errors     <= 0;
            o_pixels_out <= 0;
        end else begin
            if (i_pix.valid && i_pix.ready)
                expected_pixels.push_back(adjust_pixel(
                    {i_pix.red, i_pix.green, i_pix.blue}, lightness_offset));
            if (i_cfg_wr_en)
                lightness_offset = int'($signed(i_cfg_wr_data));
            if (o_pix.valid && o_pix.ready) begin
                got = {o_pix.out_red, o_pix.out_green, o_pix.out_blue};
                o_pixels_out <= o_pixels_out + 1;
                if (expected_pixels.size() == 0) begin
                    if (o_errors < 10)
                        $display("checker: output beat %h with nothing expected", got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_pixels.pop_front();
                    if (want !== got) begin
                        if (o_errors < 10)
                            $display("checker: pixel mismatch exp r%0d g%0d b%0d got r%0d g%0d b%0d",
                                     want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

    function automatic int pending();
        return expected_pixels.size();
    endfunction
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Drives random and directed pixels with random gaps and output stalls,
// steps the lightness offset through several values, and reports a verdict.
// ============================================================================
module tb_top;
    localparam int LATENCY   = 19;
    localparam int WATCHDOG  = 2000;
    localparam int N_RANDOM  = 950;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [7:0] i_cfg_wr_data;
    int         errors;
    int         pixels_out;
    int         pixels_in;
    int         idle_cycles;

    rhla_in_if  pix_in ();
    rhla_out_if pix_out ();

    rgb_hsl_lightness_adjust dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_pix         (pix_in.sink),
        .o_pix         (pix_out.source)
    );

    tb_pixel_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_pix         (pix_in.sink),
        .o_pix         (pix_out.sink),
        .o_errors      (errors),
        .o_pixels_out  (pixels_out)
    );

    // 8 ns clock.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Mostly short gaps, occasionally a long one.
    function automatic int gap_len();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45) return 0;
        if (sel < 90) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // Output stall pattern: phases of no stall and phases of random stall.
    always @(posedge i_clk) begin
        int hold;
        if (!i_rst_n) begin
            pix_out.ready <= 1'b0;
            hold = 0;
        end else if (hold > 0) begin
            hold--;
        end else begin
            pix_out.ready <= ~pix_out.ready;
            hold = pix_out.ready ? gap_len() : $urandom_range(40);
        end
    end

    // Watchdog on cycles with no accepted beat.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Valid stays high into the next beat only when that beat follows at once.
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.red   <= r;
        pix_in.green <= g;
        pix_in.blue  <= b;
        do @(posedge i_clk); while (!pix_in.ready);
        pixels_in++;
    endtask

    // Drain everything, let the pipeline settle, then write the register.
    task automatic set_offset(logic [7:0] value);
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (checker_inst.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_pixel();
        logic [7:0] v;
        int         kind;
        kind = $urandom_range(9);
        v = 8'($urandom_range(255));
        case (kind)
            0: send_pixel(v, v, v);
            1: send_pixel(v, v, 8'($urandom_range(255)));
            2: send_pixel(8'($urandom_range(255)), v, v);
            default: send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                                8'($urandom_range(255)));
        endcase
    endtask

    initial begin
        logic [7:0] offsets[8];
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 8'd0;
        pix_in.valid  = 1'b0;
        pix_in.red    = 8'd0;
        pix_in.green  = 8'd0;
        pix_in.blue   = 8'd0;
        pixels_in     = 0;
        offsets = '{8'sd0, 8'sd100, -8'sd100, 8'sd37, -8'sd55, 8'sd127, -8'sd128, 8'sd10};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: greys, primaries, secondaries, hue wrap and saturation edges,
        // under the reset offset.
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd1, 8'd0);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd170, 8'd85, 8'd85);
        send_pixel(8'd127, 8'd128, 8'd129);
        send_pixel(8'd64, 8'd200, 8'd10);

        // Random pixels in phases, each under its own offset.
        foreach (offsets[k]) begin
            set_offset(offsets[k]);
            repeat (N_RANDOM / 8) random_pixel();
        end

        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (checker_inst.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);

        $display("tb_top: %0d pixels sent, %0d checked across %0d offset settings",
                 pixels_in, pixels_out, 9);
        if (errors == 0 && checker_inst.pending() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
